### hdl/wdm_pkg.sv
// Shared types, constants and helpers for the task watchdog monitor.
package wdm_pkg;

   localparam int NUM_CHANNELS  = 7;
   localparam int COUNTER_WIDTH = 16;
   localparam int LIMIT_W       = 16;
   localparam int CTRL_W        = 5;
   localparam int TASK_W        = 4;
   localparam int CODE_W        = 3;
   localparam int TICK_W        = 32;
   localparam int NUM_REGS      = NUM_CHANNELS + 1;
   localparam int ADDR_W        = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int CMP_W         = (COUNTER_WIDTH > LIMIT_W) ? COUNTER_WIDTH : LIMIT_W;
   localparam int REQ_DATA_W    = 8;
   localparam int RSP_DATA_W    = 40;

   localparam logic [ADDR_W-1:0] REG_CONTROL = ADDR_W'(0);
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1000);

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_KICK = 1'b1;

   // control register bits
   localparam int CTRL_MON_ON  = 0;
   localparam int CTRL_EN_MODBUS = 1;
   localparam int CTRL_EN_SNMP   = 2;
   localparam int CTRL_EN_GSM    = 3;
   localparam int CTRL_EN_FLASH  = 4;

   typedef logic [COUNTER_WIDTH-1:0] counter_type;

   typedef struct packed {
      logic [CTRL_W-1:0]                      control;
      logic [NUM_CHANNELS-1:0][LIMIT_W-1:0]   limits;
   } cfg_type;

   typedef struct packed {
      logic [CODE_W-1:0] fault_code;
      logic              fault_latched;
      logic [TICK_W-1:0] tick_count;
   } result_type;

   // System, ethernet and usb channels have no enable bit and always count.
   function automatic logic chan_enabled(input int ch, input logic [CTRL_W-1:0] control);
      logic en;
      case (ch)
         0:       en = control[CTRL_EN_MODBUS];
         4:       en = control[CTRL_EN_SNMP];
         5:       en = control[CTRL_EN_GSM];
         6:       en = control[CTRL_EN_FLASH];
         default: en = 1'b1;
      endcase
      return en;
   endfunction

endpackage

### hdl/wdm_csr.sv
// Configuration registers: control word and per-channel tick limits.
module wdm_csr
   import wdm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [ADDR_W-1:0]  csr_addr,
   input  logic [LIMIT_W-1:0] csr_wdata,
   output cfg_type            cfg
);

   logic [CTRL_W-1:0]                    control_ff;
   logic [NUM_CHANNELS-1:0][LIMIT_W-1:0] limits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) limits_ff[i] <= LIMIT_RESET;
      end else if (csr_we) begin
         if (csr_addr == REG_CONTROL) begin
            control_ff <= csr_wdata[CTRL_W-1:0];
         end
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (csr_addr == ADDR_W'(i + 1)) limits_ff[i] <= csr_wdata;
         end
      end
   end

   assign cfg.control = control_ff;
   assign cfg.limits  = limits_ff;

endmodule

### hdl/wdm_monitor.sv
// Channel counters, tick counter and sticky fault register with their update logic.
module wdm_monitor
   import wdm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              req_type,
   input  logic [TASK_W-1:0] task_id,
   input  cfg_type           cfg,
   output result_type        result
);

   counter_type [NUM_CHANNELS-1:0] count_ff, count_in;
   logic [CODE_W-1:0]              fault_ff, fault_in;
   logic [TICK_W-1:0]              tick_ff, tick_in;
   logic                           tick_on;
   logic [CODE_W-1:0]              code;

   assign tick_on = (req_type == REQ_TICK) && cfg.control[CTRL_MON_ON];

   always_comb begin
      count_in = count_ff;
      tick_in  = tick_ff;
      fault_in = fault_ff;
      code     = '0;
      if (req_type == REQ_KICK) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if ({1'b0, task_id} == (TASK_W+1)'(i)) count_in[i] = '0;
         end
      end else if (tick_on) begin
         tick_in = tick_ff + TICK_W'(1);
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (!chan_enabled(i, cfg.control)) begin
               count_in[i] = '0;
            end else if (count_ff[i] != '1) begin
               count_in[i] = count_ff[i] + COUNTER_WIDTH'(1);
            end
         end
         // lowest channel over its limit wins
         for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (CMP_W'(count_in[i]) > CMP_W'(cfg.limits[i])) code = CODE_W'(i + 1);
         end
         if (fault_ff == '0) fault_in = code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fault_ff <= '0;
         tick_ff  <= '0;
      end else if (fire) begin
         count_ff <= count_in;
         fault_ff <= fault_in;
         tick_ff  <= tick_in;
      end
   end

   assign result.fault_code    = fault_in;
   assign result.fault_latched = (fault_in != '0);
   assign result.tick_count    = tick_in;

endmodule

### hdl/multi_task_watchdog_monitor_core.sv
// Top level of the task watchdog monitor: input register, monitor and result register.
// A beat moves from the input register through the monitor to the result register.
// Throughput: one beat per cycle, unless a result held on rsp_tready stalls the pipe.
// A result waiting on rsp_tready does not block intake while the input register is free.
// Synchronous active-high reset clears counters, tick count, fault code and control,
// and sets all limits to 1000.
module multi_task_watchdog_monitor_core
   import wdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [3:0] task_id, rest zero
   input  logic [0:0]            req_tuser,   // [0] req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [2:0] fault_code, [3] fault_latched,
                                              // [35:4] tick_count, rest zero
   input  logic                  csr_we,
   input  logic [ADDR_W-1:0]     csr_addr,
   input  logic [LIMIT_W-1:0]    csr_wdata
);

   logic              in_valid_ff;
   logic              in_type_ff;
   logic [TASK_W-1:0] in_task_ff;
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;
   result_type        result;
   cfg_type           cfg;
   logic              advance;
   logic              fire;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign fire       = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_type_ff <= req_tuser[0];
         in_task_ff <= req_tdata[TASK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) rsp_data_ff <= result;
   end

   wdm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wdm_monitor u_monitor (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req_type (in_type_ff),
      .task_id  (in_task_ff),
      .cfg      (cfg),
      .result   (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - TICK_W - 1 - CODE_W)'(0),
                        rsp_data_ff.tick_count,
                        rsp_data_ff.fault_latched,
                        rsp_data_ff.fault_code};

endmodule
